### sv/split_block_bloom_filter_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef SPLIT_BLOCK_BLOOM_FILTER_ASSERT_SVH
`define SPLIT_BLOCK_BLOOM_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBBF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sbbf_pkg.sv
package sbbf_pkg;

  localparam int MAX_LOG_BUCKETS  = 10;
  localparam int WORDS_PER_BUCKET = 8;
  localparam int ADDR_W           = MAX_LOG_BUCKETS;
  localparam int DEPTH            = 1 << MAX_LOG_BUCKETS;
  localparam int WORD_W           = 32;
  localparam int ROW_W            = WORDS_PER_BUCKET * WORD_W;
  localparam int WSEL_W           = $clog2(WORDS_PER_BUCKET);
  localparam int BITPOS_W         = $clog2(WORD_W);

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  localparam logic [3:0] LOG_RESET = 4'd10;
  localparam logic [3:0] LOG_MIN   = 4'd1;
  localparam logic [3:0] LOG_MAX   = 4'(MAX_LOG_BUCKETS);

  typedef logic [WORDS_PER_BUCKET-1:0][WORD_W-1:0] salt_arr_t;

  // split-block salts, word 0 in the lowest slot
  localparam salt_arr_t SALT = {
    32'h5c6bfb31, 32'h9efc4947, 32'h2df1424b, 32'h705495c7,
    32'ha2b7289d, 32'h8824ad5b, 32'h44974d91, 32'h47b6137b
  };

  typedef logic [WORDS_PER_BUCKET-1:0][BITPOS_W-1:0] bitpos_t;

  // decoded request, handed from the front end to the update stage
  typedef struct packed {
    logic [1:0]        req;
    logic [ADDR_W-1:0] addr;
    logic [WSEL_W-1:0] word_sel;
    logic [WORD_W-1:0] word_value;
    bitpos_t           bitpos;
  } sbbf_req_t;

  // directory write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  data;
  } sbbf_wr_t;

endpackage

### sv/sbbf_hash.sv
module sbbf_hash (
  input  logic [1:0]                  req_type,
  input  logic [63:0]                 key_hash,
  input  logic [12:0]                 word_index,
  input  logic [31:0]                 word_value,
  input  logic [3:0]                  log_bucket_count,
  output sbbf_pkg::sbbf_req_t         req
);

  logic [3:0]  eff_log;
  logic [5:0]  shamt;
  logic [31:0] upper;
  logic [31:0] lower;
  logic [31:0] shifted;
  logic [sbbf_pkg::WORDS_PER_BUCKET-1:0][31:0] prod;

  assign upper = key_hash[63:32];
  assign lower = key_hash[31:0];

  always_comb begin
    if (log_bucket_count < sbbf_pkg::LOG_MIN) begin
      eff_log = sbbf_pkg::LOG_MIN;
    end else if (log_bucket_count > sbbf_pkg::LOG_MAX) begin
      eff_log = sbbf_pkg::LOG_MAX;
    end else begin
      eff_log = log_bucket_count;
    end
  end

  assign shamt   = 6'd32 - {2'b00, eff_log};
  assign shifted = upper >> shamt;

  // one salt multiplier per word lane, low 32 bits kept
  always_comb begin
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BUCKET; i++) begin
      prod[i] = sbbf_pkg::SALT[i] * lower;
    end
  end

  always_comb begin
    req.req        = req_type;
    req.word_sel   = word_index[sbbf_pkg::WSEL_W-1:0];
    req.word_value = word_value;
    if (req_type == sbbf_pkg::REQ_LOAD) begin
      req.addr = word_index[sbbf_pkg::WSEL_W +: sbbf_pkg::ADDR_W];
    end else begin
      req.addr = shifted[sbbf_pkg::ADDR_W-1:0];
    end
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BUCKET; i++) begin
      req.bitpos[i] = prod[i][31 -: sbbf_pkg::BITPOS_W];
    end
  end

endmodule

### sv/sbbf_ram.sv
module sbbf_ram (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [sbbf_pkg::ADDR_W-1:0] rd_addr,
  output logic [sbbf_pkg::ROW_W-1:0]  rd_data,
  input  sbbf_pkg::sbbf_wr_t          wr
);

  logic [sbbf_pkg::ROW_W-1:0] mem [sbbf_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/split_block_bloom_filter.sv
// Result path: the request and directory row register into the update stage, then the result into the output register.
// Throughput: one transaction per cycle unless m_axis_tready holds the output
//   register; the directory row read-modify-write is forwarded from the last
//   write, so back-to-back hits on one bucket run at full rate.
// Reset: rst is synchronous, active high. After reset a clearing pass zeroes
//   all 1024 directory rows, one per cycle; s_axis_tready stays low until it ends.
`include "split_block_bloom_filter_assert.svh"

module split_block_bloom_filter (
  input  logic         clk,
  input  logic         rst,
  // configuration: log_bucket_count
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // key_hash[63:0], word_index[76:64],
                                      // word_value[108:77], zero pad
  input  logic [1:0]   s_axis_tuser,  // req_type
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // found[0], zero pad
  output logic [1:0]   m_axis_tuser   // done_type
);

  // configuration register
  logic [3:0] log_bucket_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_bucket_count <= sbbf_pkg::LOG_RESET;
    end else if (cfg_we) begin
      log_bucket_count <= cfg_wdata;
    end
  end

  // clearing pass after reset
  logic                        clearing;
  logic [sbbf_pkg::ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == sbbf_pkg::ADDR_W'(sbbf_pkg::DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // front end: bucket select and salt products
  sbbf_pkg::sbbf_req_t req_in;

  sbbf_hash u_hash (
    .req_type         (s_axis_tuser),
    .key_hash         (s_axis_tdata[63:0]),
    .word_index       (s_axis_tdata[76:64]),
    .word_value       (s_axis_tdata[108:77]),
    .log_bucket_count (log_bucket_count),
    .req              (req_in)
  );

  // handshake: update stage advances when the output register is free or drains
  logic in_fire;
  logic s1_valid;
  logic adv;
  logic out_valid;

  assign adv           = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid || adv);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // update stage registers; the directory row read lands alongside
  sbbf_pkg::sbbf_req_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= req_in;
    end
  end

  // directory
  logic [sbbf_pkg::ROW_W-1:0] rd_data;
  sbbf_pkg::sbbf_wr_t         wr;
  sbbf_pkg::sbbf_wr_t         upd_wr;

  sbbf_ram u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (req_in.addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // last committed write, forwarded when the read raced it
  logic                        wb_valid;
  logic [sbbf_pkg::ADDR_W-1:0] wb_addr;
  logic [sbbf_pkg::ROW_W-1:0]  wb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (upd_wr.en) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_wr.en) begin
      wb_addr <= upd_wr.addr;
      wb_data <= upd_wr.data;
    end
  end

  // read-modify-write
  logic [sbbf_pkg::WORDS_PER_BUCKET-1:0][sbbf_pkg::WORD_W-1:0] cur_row;
  logic [sbbf_pkg::WORDS_PER_BUCKET-1:0][sbbf_pkg::WORD_W-1:0] mask_row;
  logic [sbbf_pkg::WORDS_PER_BUCKET-1:0][sbbf_pkg::WORD_W-1:0] new_row;
  logic [sbbf_pkg::WORDS_PER_BUCKET-1:0]                       word_hit;
  logic                                                        all_hit;
  logic                                                        empty;
  logic                                                        found_next;

  always_comb begin
    if (wb_valid && (wb_addr == s1.addr)) begin
      cur_row = wb_data;
    end else begin
      cur_row = rd_data;
    end
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BUCKET; i++) begin
      mask_row[i] = sbbf_pkg::WORD_W'(1) << s1.bitpos[i];
      word_hit[i] = |(cur_row[i] & mask_row[i]);
    end
    all_hit = &word_hit;
  end

  always_comb begin
    new_row       = cur_row;
    upd_wr.en     = 1'b0;
    upd_wr.addr   = s1.addr;
    found_next    = 1'b0;
    case (s1.req)
      sbbf_pkg::REQ_INSERT: begin
        new_row   = cur_row | mask_row;
        upd_wr.en = adv;
      end
      sbbf_pkg::REQ_QUERY: begin
        found_next = !empty && all_hit;
      end
      sbbf_pkg::REQ_LOAD: begin
        new_row[s1.word_sel] = s1.word_value;
        upd_wr.en            = adv;
      end
      default: begin
        // unknown request: no change, result only
      end
    endcase
    upd_wr.data = new_row;
  end

  // clearing pass owns the write port until done
  always_comb begin
    if (clearing) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr;
      wr.data = '0;
    end else begin
      wr = upd_wr;
    end
  end

  // empty flag: cleared by any committed insert or load
  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else if (upd_wr.en) begin
      empty <= 1'b0;
    end
  end

  // output register
  logic       out_found;
  logic [1:0] out_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_found <= found_next;
      out_type  <= s1.req;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_found};
  assign m_axis_tuser  = out_type;

  `SBBF_ASSERT_NOW(a_no_accept_clear, clk, rst, clearing, !s_axis_tready && !s1_valid,
    "request taken during clearing pass")
  `SBBF_ASSERT_NOW(a_found_query, clk, rst, out_valid && out_found,
    out_type == sbbf_pkg::REQ_QUERY, "found set on a non-query result")
  `SBBF_ASSERT_NEXT(a_write_clears_empty, clk, rst, upd_wr.en && !clearing, !empty,
    "empty flag still set after a directory write")
  `SBBF_ASSERT_NOW(a_write_only_on_adv, clk, rst, upd_wr.en, adv && !clearing,
    "directory update without a completing transaction")

endmodule
